>>> design/chunked_file_reassembler_defines.svh
// ----------------------------------------------------------------------------
// Chunked file reassembler assertion macros
// Shared property forms for the checks inside the design.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_FILE_REASSEMBLER_DEFINES_SVH
`define CHUNKED_FILE_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked file reassembler check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define CFR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked file reassembler check failed");

`endif

>>> design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// Chunked file reassembler package
// Beat types, result codes and shared widths.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CHUNK_W     = 9;
    localparam int RCOUNT_W    = 17;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [2:0] KIND_REQ    = 3'd0;
    localparam logic [2:0] KIND_PAY    = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_ABSENT = 3'd3;
    localparam logic [2:0] KIND_ERR    = 3'd4;

    localparam logic [7:0] PRIORITY_BYTE = 8'd2;

    typedef struct packed {
        logic        action;
        logic [1:0]  archive_sel;
        logic [15:0] file_id;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] address;
        logic [15:0] total_size;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } burst_t;

endpackage

>>> design/chunked_file_reassembler.sv
// ----------------------------------------------------------------------------
// Chunked file reassembler
// Client side of a chunked file-fetch protocol: sends the request bytes,
// checks each chunk header and delivers payload bytes with their offsets.
// ----------------------------------------------------------------------------
// An item enters an input register, is decoded against the transfer state
// and its results are loaded into a burst register that drives the result
// port. Received bytes flow at one item per clock while the result port is not
// stalled; a start item yields four request beats and a completing byte yields
// two, so the input then waits while the single result port drains the burst.
// An accepted item passes the input register and then the burst register.
`include "chunked_file_reassembler_defines.svh"

module chunked_file_reassembler #(
    parameter int CHUNK_PAYLOAD = 500
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cfr_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output cfr_pkg::result_t  result
);

    cfr_pkg::item_t  item_reg;
    logic            held_reg;
    logic            load_ok;
    logic            advance;
    cfr_pkg::burst_t burst;

    assign advance    = held_reg && load_ok;
    assign item_stall = held_reg && !load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            held_reg <= 1'b1;
        end
        else if (advance)
        begin
            held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    cfr_core #(
        .CHUNK_PAYLOAD (CHUNK_PAYLOAD)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_reg),
        .commit  (advance),
        .burst   (burst)
    );

    cfr_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .burst        (burst),
        .load         (advance),
        .load_ok      (load_ok),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // A start beat always produces the full four-beat request.
    `CFR_ASSERT_IMP(a_start_four, advance && item_reg.action == cfr_pkg::ACT_START, burst.count == 3'd4)
    // The input only backs up while a result is still waiting.
    `CFR_ASSERT_IMP(a_stall_cause, item_stall, result_valid)

endmodule

>>> design/cfr_core.sv
// ----------------------------------------------------------------------------
// Chunked file reassembler protocol core
// Holds the transfer state and turns one item into its burst of results.
// ----------------------------------------------------------------------------
`include "chunked_file_reassembler_defines.svh"

module cfr_core #(
    parameter int CHUNK_PAYLOAD = 500
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfr_pkg::item_t  item_in,
    input  logic            commit,
    output cfr_pkg::burst_t burst
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    localparam logic [cfr_pkg::RCOUNT_W-1:0] CP_WIDE = cfr_pkg::RCOUNT_W'(CHUNK_PAYLOAD);

    phase_t                        phase_reg, phase_next;
    logic [2:0]                    hcount_reg, hcount_next;
    logic [39:0]                   hstore_reg, hstore_next;
    logic [1:0]                    exp_arch_reg, exp_arch_next;
    logic [15:0]                   exp_file_reg, exp_file_next;
    logic                          tknown_reg, tknown_next;
    logic [15:0]                   tlen_reg, tlen_next;
    logic [15:0]                   waddr_reg, waddr_next;
    logic [cfr_pkg::CHUNK_W-1:0]   cleft_reg, cleft_next;
    logic [cfr_pkg::RCOUNT_W-1:0]  rcount_reg, rcount_next;

    logic [7:0]                    hdr_arch;
    logic [15:0]                   hdr_file;
    logic [15:0]                   hdr_total;
    logic [15:0]                   eff_total;
    logic [cfr_pkg::RCOUNT_W-1:0]  offset;
    logic [cfr_pkg::RCOUNT_W-1:0]  remain;
    logic [cfr_pkg::RCOUNT_W-1:0]  ccount;
    logic [cfr_pkg::CHUNK_W-1:0]   cleft_dec;
    logic [cfr_pkg::RCOUNT_W-1:0]  rcount_inc;

    function automatic cfr_pkg::result_t mk(input logic [2:0] kind, input logic [7:0] data,
                                            input logic [15:0] addr, input logic [15:0] total,
                                            input logic last);
        cfr_pkg::result_t r;
        r.kind       = kind;
        r.data_byte  = data;
        r.address    = addr;
        r.total_size = total;
        r.last       = last;
        return r;
    endfunction

    assign hdr_arch   = hstore_reg[39:32];
    assign hdr_file   = hstore_reg[31:16];
    assign hdr_total  = hstore_reg[15:0];
    assign eff_total  = tknown_reg ? tlen_reg : hdr_total;
    assign offset     = cfr_pkg::RCOUNT_W'(item_in.rx_byte) * CP_WIDE;
    assign remain     = {1'b0, eff_total} - offset;
    assign ccount     = (remain > CP_WIDE) ? CP_WIDE : remain;
    assign cleft_dec  = cleft_reg - 1'b1;
    assign rcount_inc = rcount_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        hstore_next   = hstore_reg;
        exp_arch_next = exp_arch_reg;
        exp_file_next = exp_file_reg;
        tknown_next   = tknown_reg;
        tlen_next     = tlen_reg;
        waddr_next    = waddr_reg;
        cleft_next    = cleft_reg;
        rcount_next   = rcount_reg;
        burst         = '0;

        if (item_in.action == cfr_pkg::ACT_START)
        begin
            exp_arch_next = item_in.archive_sel;
            exp_file_next = item_in.file_id;
            hcount_next   = '0;
            hstore_next   = '0;
            tknown_next   = 1'b0;
            tlen_next     = '0;
            waddr_next    = '0;
            cleft_next    = '0;
            rcount_next   = '0;
            phase_next    = PH_HEADER;
            burst.count   = 3'd4;
            burst.res[0]  = mk(cfr_pkg::KIND_REQ, {6'd0, item_in.archive_sel}, '0, '0, 1'b0);
            burst.res[1]  = mk(cfr_pkg::KIND_REQ, item_in.file_id[15:8], '0, '0, 1'b0);
            burst.res[2]  = mk(cfr_pkg::KIND_REQ, item_in.file_id[7:0], '0, '0, 1'b0);
            burst.res[3]  = mk(cfr_pkg::KIND_REQ, cfr_pkg::PRIORITY_BYTE, '0, '0, 1'b1);
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hcount_reg >= 3'd5)
                    begin
                        hcount_next = '0;
                        burst.count = 3'd1;
                        if (hdr_arch != {6'd0, exp_arch_reg} || hdr_file != exp_file_reg)
                        begin
                            phase_next   = PH_IDLE;
                            burst.res[0] = mk(cfr_pkg::KIND_ERR, '0, '0, '0, 1'b1);
                        end
                        else if (hdr_total == 16'd0)
                        begin
                            phase_next   = PH_IDLE;
                            burst.res[0] = mk(cfr_pkg::KIND_ABSENT, '0, '0, '0, 1'b1);
                        end
                        else
                        begin
                            tknown_next = 1'b1;
                            tlen_next   = eff_total;
                            if (tknown_reg && hdr_total != tlen_reg)
                            begin
                                phase_next   = PH_IDLE;
                                burst.res[0] = mk(cfr_pkg::KIND_ERR, '0, '0, '0, 1'b1);
                            end
                            else if (offset >= {1'b0, eff_total})
                            begin
                                phase_next   = PH_IDLE;
                                burst.res[0] = mk(cfr_pkg::KIND_ERR, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                burst.count = 3'd0;
                                waddr_next  = offset[15:0];
                                cleft_next  = ccount[cfr_pkg::CHUNK_W-1:0];
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                    else
                    begin
                        hstore_next = {hstore_reg[31:0], item_in.rx_byte};
                        hcount_next = hcount_reg + 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    waddr_next  = waddr_reg + 1'b1;
                    cleft_next  = cleft_dec;
                    rcount_next = rcount_inc;
                    if (cleft_dec != '0)
                    begin
                        burst.count  = 3'd1;
                        burst.res[0] = mk(cfr_pkg::KIND_PAY, item_in.rx_byte, waddr_reg, '0,
                                          1'b1);
                    end
                    else if (rcount_inc >= {1'b0, tlen_reg})
                    begin
                        phase_next   = PH_IDLE;
                        burst.count  = 3'd2;
                        burst.res[0] = mk(cfr_pkg::KIND_PAY, item_in.rx_byte, waddr_reg, '0,
                                          1'b0);
                        burst.res[1] = mk(cfr_pkg::KIND_DONE, '0, '0, tlen_reg, 1'b1);
                    end
                    else
                    begin
                        phase_next   = PH_HEADER;
                        hcount_next  = '0;
                        burst.count  = 3'd1;
                        burst.res[0] = mk(cfr_pkg::KIND_PAY, item_in.rx_byte, waddr_reg, '0,
                                          1'b1);
                    end
                end
                default:
                begin
                    burst.count = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hcount_reg   <= '0;
            hstore_reg   <= '0;
            exp_arch_reg <= '0;
            exp_file_reg <= '0;
            tknown_reg   <= 1'b0;
            tlen_reg     <= '0;
            waddr_reg    <= '0;
            cleft_reg    <= '0;
            rcount_reg   <= '0;
        end
        else if (commit)
        begin
            phase_reg    <= phase_next;
            hcount_reg   <= hcount_next;
            hstore_reg   <= hstore_next;
            exp_arch_reg <= exp_arch_next;
            exp_file_reg <= exp_file_next;
            tknown_reg   <= tknown_next;
            tlen_reg     <= tlen_next;
            waddr_reg    <= waddr_next;
            cleft_reg    <= cleft_next;
            rcount_reg   <= rcount_next;
        end
    end

    // A chunk in progress always has a known, nonzero file length.
    `CFR_ASSERT_IMP(a_payload_has_total, phase_reg == PH_PAYLOAD, tknown_reg && tlen_reg != 16'd0)

endmodule

>>> design/cfr_emit.sv
// ----------------------------------------------------------------------------
// Chunked file reassembler result emitter
// Holds one burst of results and presents them one beat at a time.
// ----------------------------------------------------------------------------
`include "chunked_file_reassembler_defines.svh"

module cfr_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  cfr_pkg::burst_t   burst,
    input  logic              load,
    output logic              load_ok,
    output logic              result_valid,
    input  logic              result_stall,
    output cfr_pkg::result_t  result
);

    cfr_pkg::result_t [cfr_pkg::MAX_RESULTS-1:0] res_reg;
    logic [2:0]                                  cnt_reg;
    logic                                        take;

    assign result_valid = (cnt_reg != 3'd0);
    assign result       = res_reg[0];
    assign take         = result_valid && !result_stall;
    assign load_ok      = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst.count;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= burst.res;
        end
        else if (take)
        begin
            res_reg <= {res_reg[cfr_pkg::MAX_RESULTS-1], res_reg[cfr_pkg::MAX_RESULTS-1:1]};
        end
    end

    // The beat marked last is the final one held in the burst.
    `CFR_ASSERT_IMP(a_last_is_final, result_valid && result.last, cnt_reg == 3'd1)
    // A burst that carries results is shown on the next cycle.
    `CFR_ASSERT_NXT(a_load_shows, load && burst.count != 3'd0, result_valid)

endmodule
